// File: rtl/core/sdfb_pkg.sv
// Shared types and constants for the sphere / rounded-box distance block.
package sdfb_pkg;

  // Field and datapath widths
  localparam int CoordW = 32;   // signed Q16.16 point coordinate
  localparam int MagW   = 32;   // magnitude of a coordinate, up to 2^31
  localparam int QW     = 33;   // signed |p| - half extent
  localparam int ExtW   = 31;   // radius and half extents
  localparam int SumW   = 64;   // sum of three squares, Q32.32
  localparam int RootW  = 32;   // integer square root of SumW bits
  localparam int RemW   = 35;   // square root remainder after shifting in two bits
  localparam int AdjW   = 34;   // interior term minus radius
  localparam int DistW  = 35;   // root plus adjustment before clipping
  localparam int AddrW  = 5;    // APB byte address
  localparam int DataW  = 32;   // APB data

  // Register reset values (1.0 in Q16.16)
  localparam logic [ExtW-1:0] RadiusRst = ExtW'(65536);
  localparam logic [ExtW-1:0] HalfRst   = ExtW'(65536);

  // Register map, word index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_SHAPE_KIND = 3'd0,
    REG_RADIUS     = 3'd1,
    REG_HALF_X     = 3'd2,
    REG_HALF_Y     = 3'd3,
    REG_HALF_Z     = 3'd4
  } reg_idx_e;

  typedef enum logic {
    SHAPE_SPHERE      = 1'b0,
    SHAPE_ROUNDED_BOX = 1'b1
  } shape_e;

  // Input word: one point
  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
  } in_word_t;

  // Output word: one distance
  typedef struct packed {
    logic signed [CoordW-1:0] distance;
    logic                     saturated;
  } out_word_t;

  // Square root pipe payload, with the additive term riding alongside
  typedef struct packed {
    logic [SumW-1:0]        rad;
    logic signed [AdjW-1:0] adj;
  } isq_in_t;

  typedef struct packed {
    logic [RootW-1:0]       root;
    logic signed [AdjW-1:0] adj;
  } isq_out_t;

endpackage

// File: rtl/core/sdfb_isqrt.sv
// Pipelined integer square root, one root bit per stage, with a sideband term.
module sdfb_isqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  sdfb_pkg::isq_in_t data_i,
  output logic              valid_o,
  output sdfb_pkg::isq_out_t data_o
);
  import sdfb_pkg::*;

  // Per-stage registers, one entry per root bit
  logic                   vld_q  [RootW];
  logic [SumW-1:0]        rad_q  [RootW];
  logic [RemW-1:0]        rem_q  [RootW];
  logic [RootW-1:0]       root_q [RootW];
  logic signed [AdjW-1:0] adj_q  [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_stg
    logic                   vld_in;
    logic [SumW-1:0]        rad_in;
    logic [RemW-1:0]        rem_in;
    logic [RootW-1:0]       root_in;
    logic signed [AdjW-1:0] adj_in;
    logic [RemW-1:0]        acc;
    logic [RemW-1:0]        trial;
    logic                   fit;

    if (s == 0) begin : g_head
      assign vld_in  = valid_i;
      assign rad_in  = data_i.rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign adj_in  = data_i.adj;
    end else begin : g_body
      assign vld_in  = vld_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign adj_in  = adj_q[s-1];
    end

    // Bring down the next two radicand bits and try root*4+1
    assign acc   = {rem_in[RemW-3:0], rad_in[SumW-1 -: 2]};
    assign trial = {{(RemW-RootW-2){1'b0}}, root_in, 2'b01};
    assign fit   = (acc >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s]  <= {rad_in[SumW-3:0], 2'b00};
        rem_q[s]  <= fit ? (acc - trial) : acc;
        root_q[s] <= {root_in[RootW-2:0], fit};
        adj_q[s]  <= adj_in;
      end
    end
  end

  assign valid_o     = vld_q[RootW-1];
  assign data_o.root = root_q[RootW-1];
  assign data_o.adj  = adj_q[RootW-1];

endmodule

// File: rtl/core/sdf_sphere_rounded_box_distance.sv
// Top level: signed distance from a Q16.16 point to a sphere or a rounded box.
//
// One point is taken per cycle unless the output word is held; each gives one
// distance word through four front stages (absolute value, offset by the half
// extents, squares, sum of squares), 32 square root stages that each settle one
// root bit, and the output register. The whole pipe advances together and holds
// while the output word waits, so a stall loses no word. The user must write
// configuration over APB only while no point is in flight (unenforced): shape
// kind at 0x00, radius at 0x04, half extents x/y/z at 0x08, 0x0C, 0x10.
module sdf_sphere_rounded_box_distance (
  input  logic                clk_i,
  input  logic                rst_ni,
  // point input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sdfb_pkg::in_word_t  in_data_i,
  // distance output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sdfb_pkg::out_word_t out_data_o,
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import sdfb_pkg::*;

  // Magnitude of a signed coordinate; -2^31 maps to 2^31
  function automatic logic [MagW-1:0] mag(input logic signed [CoordW-1:0] v);
    logic [CoordW:0] w;
    w   = {v[CoordW-1], v};
    mag = v[CoordW-1] ? MagW'((CoordW+1)'(0) - w) : MagW'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  shape_e          shape_q;
  logic [ExtW-1:0] radius_q, half_x_q, half_y_q, half_z_q;
  reg_idx_e        reg_idx;
  logic            wr_en;

  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= SHAPE_SPHERE;
      radius_q <= RadiusRst;
      half_x_q <= HalfRst;
      half_y_q <= HalfRst;
      half_z_q <= HalfRst;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SHAPE_KIND: shape_q  <= shape_e'(pwdata[0]);
        REG_RADIUS:     radius_q <= pwdata[ExtW-1:0];
        REG_HALF_X:     half_x_q <= pwdata[ExtW-1:0];
        REG_HALF_Y:     half_y_q <= pwdata[ExtW-1:0];
        REG_HALF_Z:     half_z_q <= pwdata[ExtW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_SHAPE_KIND: prdata = {{(DataW-1){1'b0}}, shape_q};
      REG_RADIUS:     prdata = {1'b0, radius_q};
      REG_HALF_X:     prdata = {1'b0, half_x_q};
      REG_HALF_Y:     prdata = {1'b0, half_y_q};
      REG_HALF_Z:     prdata = {1'b0, half_z_q};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipe advance: everything moves unless the output word is held
  // ---------------------------------------------------------------------------
  logic adv;
  assign adv        = ~out_valid_o | out_ready_i;
  assign in_ready_o = adv;

  // ---------------------------------------------------------------------------
  // Stage 1: coordinate magnitudes
  // ---------------------------------------------------------------------------
  logic            s1_vld_q;
  shape_e          s1_shape_q;
  logic [MagW-1:0] s1_ax_q, s1_ay_q, s1_az_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_shape_q <= shape_q;
      s1_ax_q    <= mag(in_data_i.px);
      s1_ay_q    <= mag(in_data_i.py);
      s1_az_q    <= mag(in_data_i.pz);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: q = |p| - half extent, pick length components
  // ---------------------------------------------------------------------------
  logic signed [QW-1:0] qx, qy, qz;
  logic [MagW-1:0]      cx, cy, cz;
  logic                 s2_vld_q;
  shape_e               s2_shape_q;
  logic signed [QW-1:0] s2_qx_q, s2_qy_q, s2_qz_q;
  logic [MagW-1:0]      s2_cx_q, s2_cy_q, s2_cz_q;

  assign qx = $signed({1'b0, s1_ax_q}) - $signed({2'b00, half_x_q});
  assign qy = $signed({1'b0, s1_ay_q}) - $signed({2'b00, half_y_q});
  assign qz = $signed({1'b0, s1_az_q}) - $signed({2'b00, half_z_q});

  // Sphere uses |p|, box uses q clamped at zero
  always_comb begin
    if (s1_shape_q == SHAPE_ROUNDED_BOX) begin
      cx = qx[QW-1] ? '0 : qx[MagW-1:0];
      cy = qy[QW-1] ? '0 : qy[MagW-1:0];
      cz = qz[QW-1] ? '0 : qz[MagW-1:0];
    end else begin
      cx = s1_ax_q;
      cy = s1_ay_q;
      cz = s1_az_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_shape_q <= s1_shape_q;
      s2_qx_q    <= qx;
      s2_qy_q    <= qy;
      s2_qz_q    <= qz;
      s2_cx_q    <= cx;
      s2_cy_q    <= cy;
      s2_cz_q    <= cz;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squares, interior term minus radius
  // ---------------------------------------------------------------------------
  logic [SumW-1:0]        sqx, sqy, sqz;
  logic signed [QW-1:0]   mxy, mxyz, mneg;
  logic signed [AdjW-1:0] adj;
  logic                   s3_vld_q;
  logic [SumW-1:0]        s3_sqx_q, s3_sqy_q, s3_sqz_q;
  logic signed [AdjW-1:0] s3_adj_q;

  assign sqx = SumW'(s2_cx_q) * SumW'(s2_cx_q);
  assign sqy = SumW'(s2_cy_q) * SumW'(s2_cy_q);
  assign sqz = SumW'(s2_cz_q) * SumW'(s2_cz_q);

  // Largest q, kept only when negative (point inside the box)
  assign mxy  = (s2_qy_q > s2_qx_q) ? s2_qy_q : s2_qx_q;
  assign mxyz = (s2_qz_q > mxy) ? s2_qz_q : mxy;
  assign mneg = mxyz[QW-1] ? mxyz : '0;

  always_comb begin
    if (s2_shape_q == SHAPE_ROUNDED_BOX) begin
      adj = $signed({mneg[QW-1], mneg}) - $signed({3'b000, radius_q});
    end else begin
      adj = $signed(AdjW'(0)) - $signed({3'b000, radius_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_sqx_q <= sqx;
      s3_sqy_q <= sqy;
      s3_sqz_q <= sqz;
      s3_adj_q <= adj;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: sum of squares (at most 3 * 2^62, no carry out)
  // ---------------------------------------------------------------------------
  logic    s4_vld_q;
  isq_in_t s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (adv) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_q.rad <= s3_sqx_q + s3_sqy_q + s3_sqz_q;
      s4_q.adj <= s3_adj_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root pipe
  // ---------------------------------------------------------------------------
  logic     sq_vld;
  isq_out_t sq_res;

  sdfb_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s4_vld_q),
    .data_i  (s4_q),
    .valid_o (sq_vld),
    .data_o  (sq_res)
  );

  // ---------------------------------------------------------------------------
  // Output stage: add, clip to signed 32 bits
  // ---------------------------------------------------------------------------
  logic signed [DistW-1:0] dsum;
  logic                    d_hi, d_lo;
  logic                    out_vld_q;
  out_word_t               out_q;

  assign dsum = $signed({3'b000, sq_res.root}) + $signed({sq_res.adj[AdjW-1], sq_res.adj});
  assign d_hi = ~dsum[DistW-1] & (|dsum[DistW-2:CoordW-1]);
  assign d_lo = dsum[DistW-1] & ~(&dsum[DistW-2:CoordW-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (d_hi) begin
        out_q.distance <= {1'b0, {(CoordW-1){1'b1}}};
      end else if (d_lo) begin
        out_q.distance <= {1'b1, {(CoordW-1){1'b0}}};
      end else begin
        out_q.distance <= dsum[CoordW-1:0];
      end
      out_q.saturated <= d_hi | d_lo;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An accepted point enters the first stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_vld_q)
    else $error("accepted point did not enter stage 1");

  // Saturation only reports a clipped extreme value
  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      (out_data_o.distance == {1'b0, {(CoordW-1){1'b1}}}) ||
      (out_data_o.distance == {1'b1, {(CoordW-1){1'b0}}}))
    else $error("saturated flag with unclipped distance");

  // A stalled pipe holds its inner stages, checked here on stage 2
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv && s2_vld_q |=> s2_vld_q && $stable(s2_qx_q) && $stable(s2_cx_q))
    else $error("stage 2 changed during a stall");

endmodule

// File: sim/sdf_distance_checker.sv
// Checker for the sphere / rounded-box distance block: predicts each distance word and compares.
`timescale 1ns / 100ps

module sdf_distance_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  // point channel
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  sdfb_pkg::in_word_t  in_data_i,
  // distance channel
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  sdfb_pkg::out_word_t out_data_i,
  // APB bus, observed only
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [4:0]          paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic                pready_i,
  // status for the testbench top
  output int                  err_cnt_o,
  output int                  in_flight_o,
  output int                  checked_o,
  output int                  sat_cnt_o
);
  import sdfb_pkg::*;

  localparam int     MaxReports = 10;
  localparam longint DistMax    = 64'sd2147483647;
  localparam longint DistMin    = -64'sd2147483648;

  // one point in flight and the word it should produce
  typedef struct {
    in_word_t  pt;
    out_word_t res;
  } pending_t;

  // shadow copy of the configuration registers
  shape_e            shape_q = SHAPE_SPHERE;
  logic [ExtW-1:0]   rad_q   = RadiusRst;
  logic [ExtW-1:0]   hx_q    = HalfRst;
  logic [ExtW-1:0]   hy_q    = HalfRst;
  logic [ExtW-1:0]   hz_q    = HalfRst;

  pending_t          dist_fifo[$];
  pending_t          head;
  int                n_err     = 0;
  int                n_pending = 0;
  int                n_checked = 0;
  int                n_sat     = 0;

  assign err_cnt_o   = n_err;
  assign in_flight_o = n_pending;
  assign checked_o   = n_checked;
  assign sat_cnt_o   = n_sat;

  // floor of the square root, one root bit per pass from the top
  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root[31:0];
  endfunction

  // Euclidean length of three non-negative components, each at most 2^31
  function automatic longint vec_len(input longint a, input longint b, input longint c);
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] uc;
    ua = a;
    ub = b;
    uc = c;
    return longint'({32'b0, floor_sqrt(ua * ua + ub * ub + uc * uc)});
  endfunction

  function automatic longint clamp_pos(input longint v);
    return (v > 0) ? v : 64'sd0;
  endfunction

  // expected distance word for one point under the current registers
  function automatic out_word_t predict_distance(input in_word_t pt);
    longint    ax;
    longint    ay;
    longint    az;
    longint    qx;
    longint    qy;
    longint    qz;
    longint    peak;
    longint    d;
    out_word_t w;
    ax = longint'($signed(pt.px));
    ay = longint'($signed(pt.py));
    az = longint'($signed(pt.pz));
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    if (az < 0) az = -az;
    if (shape_q == SHAPE_SPHERE) begin
      d = vec_len(ax, ay, az) - longint'({33'b0, rad_q});
    end else begin
      qx = ax - longint'({33'b0, hx_q});
      qy = ay - longint'({33'b0, hy_q});
      qz = az - longint'({33'b0, hz_q});
      // interior term uses the largest q unclamped
      peak = qx;
      if (qy > peak) peak = qy;
      if (qz > peak) peak = qz;
      d = vec_len(clamp_pos(qx), clamp_pos(qy), clamp_pos(qz))
          + ((peak < 0) ? peak : 64'sd0) - longint'({33'b0, rad_q});
    end
    w.saturated = 1'b1;
    if (d > DistMax) begin
      w.distance = 32'h7FFF_FFFF;
    end else if (d < DistMin) begin
      w.distance = 32'h8000_0000;
    end else begin
      w.distance  = d[31:0];
      w.saturated = 1'b0;
    end
    return w;
  endfunction

  // track writes, queue predictions, compare returned words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q = SHAPE_SPHERE;
      rad_q   = RadiusRst;
      hx_q    = HalfRst;
      hy_q    = HalfRst;
      hz_q    = HalfRst;
      dist_fifo.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[4:2]))
          REG_SHAPE_KIND: shape_q = shape_e'(pwdata_i[0]);
          REG_RADIUS:     rad_q   = pwdata_i[ExtW-1:0];
          REG_HALF_X:     hx_q    = pwdata_i[ExtW-1:0];
          REG_HALF_Y:     hy_q    = pwdata_i[ExtW-1:0];
          REG_HALF_Z:     hz_q    = pwdata_i[ExtW-1:0];
          default: ;  // unmapped address, no effect
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        head.pt  = in_data_i;
        head.res = predict_distance(in_data_i);
        dist_fifo.push_back(head);
      end

      if (out_valid_i && out_ready_i) begin
        if (dist_fifo.size() == 0) begin
          n_err++;
          if (n_err <= MaxReports)
            $display("unexpected distance word: distance %h sat %b",
                     out_data_i.distance, out_data_i.saturated);
        end else begin
          head = dist_fifo.pop_front();
          n_checked++;
          if (out_data_i.saturated) n_sat++;
          if (out_data_i.distance !== head.res.distance ||
              out_data_i.saturated !== head.res.saturated) begin
            n_err++;
            if (n_err <= MaxReports)
              $display("distance mismatch, point (%h %h %h): exp %h sat %b, got %h sat %b",
                       head.pt.px, head.pt.py, head.pt.pz,
                       head.res.distance, head.res.saturated,
                       out_data_i.distance, out_data_i.saturated);
          end
        end
      end
    end
    n_pending = dist_fifo.size();
  end

endmodule

// File: sim/tb_sdf_sphere_rounded_box_distance.sv
// Testbench top for the sphere / rounded-box distance block: stimulus, config writes, verdict.
`timescale 1ns / 100ps

module tb_sdf_sphere_rounded_box_distance;
  import sdfb_pkg::*;

  localparam int              ClkHalf          = 6;
  localparam int              RstCycles        = 7;
  localparam int              IdlePct          = 6;
  localparam int              RandSettings     = 12;
  localparam int              PointsPerSetting = 119;
  localparam int              DrainCycles      = 60;
  localparam longint          TimeoutNs        = 2_400_000;
  localparam logic [ExtW-1:0] ExtMax           = '1;
  localparam logic [2:0]      UnmappedIdx [3]  = '{3'd5, 3'd6, 3'd7};

  // Q16.16 constants used by the directed points
  localparam logic [31:0] One      = 32'h0001_0000;
  localparam logic [31:0] Half     = 32'h0000_8000;
  localparam logic [31:0] Three    = 32'h0003_0000;
  localparam logic [31:0] NegThree = 32'hFFFD_0000;
  localparam logic [31:0] PosMax   = 32'h7FFF_FFFF;
  localparam logic [31:0] NegMax   = 32'h8000_0000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_word_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_word_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  int          err_cnt;
  int          in_flight;
  int          checked;
  int          sat_cnt;
  int          n_points    = 0;
  int          n_writes    = 0;
  bit          idle_on     = 1'b1;

  // settings currently loaded, used to aim random points near the surface
  logic             cur_box;
  logic [ExtW-1:0]  cur_rad;
  logic [ExtW-1:0]  cur_hx;
  logic [ExtW-1:0]  cur_hy;
  logic [ExtW-1:0]  cur_hz;
  logic [31:0]      raw;

  sdf_sphere_rounded_box_distance u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  sdf_distance_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .err_cnt_o   (err_cnt),
    .in_flight_o (in_flight),
    .checked_o   (checked),
    .sat_cnt_o   (sat_cnt)
  );

  // clock
  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // sink side: random back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= idle_on ? ($urandom_range(99) >= IdlePct) : 1'b1;
  end

  // hard stop
  initial begin
    #(TimeoutNs);
    $display("tb_sdf_sphere_rounded_box_distance NOT OK");
    $finish;
  end

  // offer one point; returns at the falling edge after it was taken, valid still high
  task automatic push_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    if (idle_on && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_data_i.px <= x;
    in_data_i.py <= y;
    in_data_i.pz <= z;
    do @(posedge clk_i); while (!in_ready_o);
    n_points++;
    @(negedge clk_i);
  endtask

  // stop offering and wait until every distance word is back
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (in_flight != 0) @(negedge clk_i);
  endtask

  // APB write: setup, access, then back to idle
  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    n_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // zero, full scale, full random, or a spread of magnitudes
  function automatic logic [ExtW-1:0] rand_ext();
    logic [31:0] v;
    case ($urandom_range(5))
      0:       v = '0;
      1:       v = {1'b0, ExtMax};
      2:       v = $urandom;
      default: v = $urandom >> $urandom_range(8, 30);
    endcase
    return v[ExtW-1:0];
  endfunction

  // coordinate: full random, near the surface, an edge value, or small
  function automatic logic [31:0] rand_coord(input logic [ExtW-1:0] ext);
    longint v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = longint'($signed($urandom));
      4, 5, 6, 7: begin
        v = longint'({33'b0, ext}) + longint'($urandom_range(0, 'h40000)) - 64'sh20000;
        if ($urandom_range(1)) v = -v;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
      end
      8: begin
        case ($urandom_range(3))
          0:       v = longint'($signed(NegMax));
          1:       v = longint'($signed(PosMax));
          2:       v = 0;
          default: v = -1;
        endcase
      end
      default: begin
        v = longint'($urandom_range(0, 'h2FFFF));
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v[31:0];
  endfunction

  // stimulus and verdict
  initial begin
    repeat (RstCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sphere at reset values: origin, on the surface, far corners saturating high
    push_point('0, '0, '0);
    push_point(One, '0, '0);
    push_point(NegMax, NegMax, NegMax);
    push_point(PosMax, PosMax, PosMax);
    push_point(32'hAAAA_AAAA, 32'h5555_5555, '0);

    // sphere with the largest radius, bits above the field set on the bus
    quiesce();
    set_reg(REG_RADIUS, 32'hFFFF_FFFF);
    push_point('0, '0, '0);

    // rounded box of unit extents; shape word carries junk above bit 0
    quiesce();
    set_reg(REG_RADIUS, One);
    set_reg(REG_SHAPE_KIND, 32'hFFFF_FFFF);
    push_point('0, '0, '0);
    push_point(One, One, One);
    push_point(Three, NegThree, Three);
    push_point(Half, '0, '0);
    push_point(NegMax, PosMax, NegMax);

    // degenerate box: zero extents and zero rounding
    quiesce();
    set_reg(REG_RADIUS, '0);
    set_reg(REG_HALF_X, '0);
    set_reg(REG_HALF_Y, '0);
    set_reg(REG_HALF_Z, '0);
    push_point('0, '0, '0);
    push_point(32'hFFFF_FFFF, '0, '0);

    // huge box with huge rounding: interior term drives saturation low
    quiesce();
    set_reg(REG_HALF_X, {1'b0, ExtMax});
    set_reg(REG_HALF_Y, {1'b0, ExtMax});
    set_reg(REG_HALF_Z, 32'hFFFF_FFFF);
    set_reg(REG_RADIUS, {1'b0, ExtMax});
    push_point('0, '0, '0);

    // lands exactly on the most negative value without clipping
    quiesce();
    set_reg(REG_RADIUS, 32'h0000_0001);
    push_point('0, '0, '0);

    // writes to unmapped addresses must leave the settings alone
    quiesce();
    foreach (UnmappedIdx[k]) set_reg(UnmappedIdx[k], '0);
    push_point('0, '0, '0);

    // random part: one setting after another, extremes first
    for (int s = 0; s < RandSettings; s++) begin
      quiesce();
      if (s == 0) begin
        cur_rad = '0;
        cur_hx  = '0;
        cur_hy  = '0;
        cur_hz  = '0;
      end else if (s == 1) begin
        cur_rad = ExtMax;
        cur_hx  = ExtMax;
        cur_hy  = ExtMax;
        cur_hz  = ExtMax;
      end else begin
        cur_rad = rand_ext();
        cur_hx  = rand_ext();
        cur_hy  = rand_ext();
        cur_hz  = rand_ext();
      end
      cur_box = s[0];
      raw = $urandom;
      raw[0] = cur_box;
      set_reg(REG_SHAPE_KIND, raw);
      raw = $urandom;
      raw[ExtW-1:0] = cur_rad;
      set_reg(REG_RADIUS, raw);
      raw = $urandom;
      raw[ExtW-1:0] = cur_hx;
      set_reg(REG_HALF_X, raw);
      raw = $urandom;
      raw[ExtW-1:0] = cur_hy;
      set_reg(REG_HALF_Y, raw);
      raw = $urandom;
      raw[ExtW-1:0] = cur_hz;
      set_reg(REG_HALF_Z, raw);

      // a run of settings with both sides streaming flat out
      idle_on = (s < 4 || s > 6);
      repeat (PointsPerSetting) begin
        if (cur_box)
          push_point(rand_coord(cur_hx), rand_coord(cur_hy), rand_coord(cur_hz));
        else
          push_point(rand_coord(cur_rad), rand_coord(cur_rad), rand_coord(cur_rad));
      end
    end

    idle_on = 1'b1;
    quiesce();
    repeat (DrainCycles) @(negedge clk_i);

    $display("run covered %0d points, sphere and rounded box, over %0d register writes",
             n_points, n_writes);
    $display("%0d distance words checked, %0d of them clipped", checked, sat_cnt);
    if (err_cnt == 0 && in_flight == 0)
      $display("tb_sdf_sphere_rounded_box_distance OK");
    else
      $display("tb_sdf_sphere_rounded_box_distance NOT OK");
    $finish;
  end

endmodule

// File: files.f
rtl/core/sdfb_pkg.sv
rtl/core/sdfb_isqrt.sv
rtl/core/sdf_sphere_rounded_box_distance.sv
sim/sdf_distance_checker.sv
sim/tb_sdf_sphere_rounded_box_distance.sv
